@@ hw/rtl/omni3_pkg.sv @@
// shared types and constants of the three-wheel omni pid drive
package omni3_pkg;

	localparam int WHEEL_COUNT = 3;
	localparam int WHEEL_W     = 2;
	localparam int PWM_BITS    = 14;
	localparam logic [PWM_BITS-1:0] PWM_MOD = '1;

	// register indexes of the configuration port
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED  = 8'd3;

	// width of the scaled drive magnitude handed to the divider
	localparam int QW = 40;

	typedef struct packed {
		logic signed [31:0] enc_pos_a;
		logic signed [31:0] enc_pos_b;
		logic signed [31:0] enc_pos_c;
		logic [7:0]         stick_x;
		logic [7:0]         stick_y;
		logic [7:0]         right_trigger;
		logic [7:0]         left_trigger;
	} tick_t;

	typedef struct packed {
		logic [PWM_BITS-1:0] fwd_a;
		logic [PWM_BITS-1:0] rev_a;
		logic [PWM_BITS-1:0] fwd_b;
		logic [PWM_BITS-1:0] rev_b;
		logic [PWM_BITS-1:0] fwd_c;
		logic [PWM_BITS-1:0] rev_c;
	} pwm_t;

	// one wheel's entry of the state memory
	typedef struct packed {
		logic [31:0]        pos;
		logic signed [31:0] integ;
		logic signed [23:0] perr;
	} st_entry_t;

	typedef struct packed {
		logic               rd;
		logic               wr;
		logic [WHEEL_W-1:0] addr;
		st_entry_t          wdata;
	} mem_req_t;

	typedef struct packed {
		logic          start;
		logic          neg;
		logic [QW-1:0] mag;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [PWM_BITS-1:0] fwd;
		logic [PWM_BITS-1:0] rev;
	} div_rsp_t;

endpackage

@@ hw/rtl/omni_three_wheel_pid_drive.sv @@
// Three-wheel omni drive with one PID speed loop per wheel.
// Tick channel (tick_valid/tick_stall/tick): one control tick carrying three
// encoder counts, two joystick axes and two triggers. A transaction completes
// at a clock edge with tick_valid high and tick_stall low.
// Result channel (pwm_valid/pwm_stall/pwm): forward and reverse PWM magnitudes
// of the three wheels, one result per tick.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): 0 prop gain,
// 1 integral gain, 2 derivative gain (Q8.8), 3 top speed in rpm; other
// indexes are ignored. Write only while the block is idle.
// Wheels are processed one after another: each reads its state entry, runs
// the setpoint, speed and error steps, six passes of the shared multiplier,
// writes its entry back and waits for the divide and modulo unit. After the
// last wheel the result is handed to the output register, and the next tick
// is taken once that hand-over is done.
// tick_stall is high while a tick is in work. A finished result sits in the
// output register while the receiver stalls; the next tick is still taken and
// worked on, and only its hand-over waits for that register to free.
// Reset clears wheel state to zero and loads the default gains.
module omni_three_wheel_pid_drive
	import omni3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	output logic                 tick_stall,
	input  tick_t                tick,
	output logic                 pwm_valid,
	input  logic                 pwm_stall,
	output pwm_t                 pwm,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_MAP  = 11'b00000000010,
		ST_RD   = 11'b00000000100,
		ST_SP   = 11'b00000001000,
		ST_SPT  = 11'b00000010000,
		ST_SPD  = 11'b00000100000,
		ST_ERR  = 11'b00001000000,
		ST_MAC  = 11'b00010000000,
		ST_WB   = 11'b00100000000,
		ST_DIV  = 11'b01000000000,
		ST_OUT  = 11'b10000000000
	} st_t;

	st_t                state_q;
	tick_t              tick_q;
	logic [WHEEL_W-1:0] whl_q;
	logic [2:0]         mac_q;

	// scaled gains: 120*kp, 9*ki, 1600*kd
	logic [22:0] gp_q;
	logic [19:0] gi_q;
	logic [26:0] gd_q;
	logic [9:0]  top_q;

	logic signed [8:0]  xm_q, ym_q, w_q;
	logic [8:0]         qv_q;
	logic               vneg_q;
	logic [19:0]        n2_q;
	logic               aneg_q;
	logic [15:0]        mag_q;
	logic               dneg_q, sat_q;
	logic signed [13:0] sp_q;
	logic signed [23:0] spd_q;
	logic signed [23:0] e_q;
	logic signed [24:0] de_q;
	logic signed [31:0] integ_q;
	logic signed [55:0] acc_q;
	pwm_t               res_q;
	pwm_t               pwm_q;
	logic               pwm_valid_q;

	mem_req_t  mreq;
	st_entry_t mrd;
	div_req_t  dreq;
	div_rsp_t  drsp;

	omni3_state_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (mrd)
	);

	omni3_pwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign tick_stall = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign pwm_valid  = pwm_valid_q;
	assign pwm        = pwm_q;

	// encoder count of the current wheel
	logic [31:0] now;
	always_comb begin
		case (whl_q)
			2'd0:    now = tick_q.enc_pos_a;
			2'd1:    now = tick_q.enc_pos_b;
			default: now = tick_q.enc_pos_c;
		endcase
	end

	// joystick range maps and turn rate
	logic signed [8:0] xm_n, ym_n, w_n;
	always_comb begin
		logic [14:0] nx, ny;
		logic [30:0] px, py;
		nx = '0;
		ny = '0;
		px = '0;
		py = '0;
		xm_n = '0;
		ym_n = '0;
		if (tick_q.stick_x < 8'd125) begin
			nx = 15'(8'd125 - tick_q.stick_x) * 15'd255;
			px = 31'(nx) * 31'(16'd33555);
			xm_n = -$signed({1'b0, px[29:22]});
		end else if (tick_q.stick_x > 8'd135) begin
			nx = 15'(tick_q.stick_x - 8'd135) * 15'd255;
			px = 31'(nx) * 31'(16'd34953);
			xm_n = $signed({1'b0, px[29:22]});
		end
		if (tick_q.stick_y > 8'd135) begin
			ny = 15'(tick_q.stick_y - 8'd135) * 15'd255;
			py = 31'(ny) * 31'(16'd34953);
			ym_n = -$signed({1'b0, py[29:22]});
		end else if (tick_q.stick_y < 8'd120) begin
			ny = 15'(8'd125 - tick_q.stick_y) * 15'd255;
			py = 31'(ny) * 31'(16'd33555);
			ym_n = $signed({1'b0, py[29:22]});
		end
		w_n = (tick_q.right_trigger != 8'd0) ? $signed({1'b0, tick_q.right_trigger})
		                                      : -$signed({1'b0, tick_q.left_trigger});
	end

	// kinematic sum in thousandths, truncated by reciprocal multiply
	logic [8:0] qv_n;
	logic       vneg_n;
	always_comb begin
		logic signed [20:0] x21, y21, w21, v;
		logic [20:0] va;
		logic [38:0] pv;
		x21 = 21'(xm_q);
		y21 = 21'(ym_q);
		w21 = 21'(w_q);
		case (whl_q)
			2'd0:    v = x21 * 21'sd1000 + w21 * 21'sd300;
			2'd1:    v = -(x21 * 21'sd500) - y21 * 21'sd852 + w21 * 21'sd300;
			default: v = -(x21 * 21'sd500) + y21 * 21'sd866 + w21 * 21'sd300;
		endcase
		va = v[20] ? 21'(-v) : 21'(v);
		pv = 39'(va[18:0]) * 39'(20'd536871);
		qv_n = pv[37:29];
		vneg_n = v[20];
	end

	// setpoint product and encoder delta
	logic [19:0] n2_n;
	logic        aneg_n;
	logic [15:0] mag_n;
	logic        dneg_n, sat_n;
	always_comb begin
		logic signed [9:0]  vs;
		logic signed [10:0] a;
		logic [10:0] aa;
		logic [31:0] d, dm;
		vs = vneg_q ? -$signed({1'b0, qv_q}) : $signed({1'b0, qv_q});
		a = 11'(vs) + 11'sd175;
		aa = a[10] ? 11'(-a) : 11'(a);
		n2_n = 20'(aa[9:0]) * 20'(top_q);
		aneg_n = a[10];
		d = now - mrd.pos;
		dm = d[31] ? -d : d;
		dneg_n = d[31];
		sat_n = (dm >= 32'd53248);
		mag_n = dm[15:0];
	end

	// setpoint division by 175
	logic signed [13:0] sp_n;
	always_comb begin
		logic [40:0] p;
		logic [11:0] q;
		p = 41'(n2_q) * 41'(21'd1533917);
		q = p[39:28];
		sp_n = $signed({4'b0, top_q}) + (aneg_q ? $signed({2'b0, q}) : -$signed({2'b0, q}));
	end

	// speed in Q16.8 rpm: mag*2048/13 as mag*157 + mag*7/13
	logic signed [23:0] spd_n;
	always_comb begin
		logic [18:0] t;
		logic [37:0] p;
		logic [22:0] s;
		t = (19'(mag_q) << 3) - 19'(mag_q);
		p = 38'(t) * 38'(19'd322639);
		s = 23'(mag_q) * 23'd157 + 23'(p[36:22]);
		if (sat_q) begin
			s = 23'h7FFFFF;
		end
		spd_n = dneg_q ? -$signed({1'b0, s}) : $signed({1'b0, s});
	end

	// error, error change and saturating integral
	logic signed [23:0] e_n;
	logic signed [24:0] de_n;
	logic signed [31:0] integ_n;
	always_comb begin
		logic signed [24:0] er;
		logic signed [32:0] is;
		er = 25'($signed({sp_q, 8'b0})) - 25'(spd_q);
		if (er > 25'sd8388607) begin
			e_n = 24'sh7FFFFF;
		end else if (er < -25'sd8388608) begin
			e_n = 24'sh800000;
		end else begin
			e_n = er[23:0];
		end
		de_n = 25'(e_n) - 25'(mrd.perr);
		is = 33'(mrd.integ) + 33'(e_n);
		if (is > 33'sd2147483647) begin
			integ_n = 32'sh7FFFFFFF;
		end else if (is < -33'sd2147483648) begin
			integ_n = 32'sh80000000;
		end else begin
			integ_n = is[31:0];
		end
	end

	// one partial product of the PID sum per cycle
	logic signed [55:0] term;
	always_comb begin
		logic [26:0] g;
		logic signed [16:0] op;
		logic signed [44:0] prod;
		logic hi;
		case (mac_q)
			3'd0: begin g = 27'(gp_q); op = $signed({1'b0, e_q[15:0]}); hi = 1'b0; end
			3'd1: begin g = 27'(gp_q); op = 17'($signed(e_q[23:16])); hi = 1'b1; end
			3'd2: begin g = 27'(gi_q); op = $signed({1'b0, integ_q[15:0]}); hi = 1'b0; end
			3'd3: begin g = 27'(gi_q); op = 17'($signed(integ_q[31:16])); hi = 1'b1; end
			3'd4: begin g = gd_q; op = $signed({1'b0, de_q[15:0]}); hi = 1'b0; end
			default: begin g = gd_q; op = 17'($signed(de_q[24:16])); hi = 1'b1; end
		endcase
		prod = 45'($signed({1'b0, g})) * 45'(op);
		term = hi ? (56'(prod) <<< 16) : 56'(prod);
	end

	// memory and divider requests
	logic [55:0] acc_mag;
	always_comb begin
		acc_mag = acc_q[55] ? 56'(-acc_q) : 56'(acc_q);
		mreq.rd = (state_q == ST_RD);
		mreq.wr = (state_q == ST_WB);
		mreq.addr = whl_q;
		mreq.wdata.pos = now;
		mreq.wdata.integ = integ_q;
		mreq.wdata.perr = e_q;
		dreq.start = (state_q == ST_WB);
		dreq.neg = acc_q[55];
		dreq.mag = QW'(acc_mag[55:19]);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q  <= 23'd276480;
			gi_q  <= 20'd380160;
			gd_q  <= 27'd204800;
			top_q <= 10'd300;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PROP_GAIN:  gp_q  <= 23'(cfg_data) * 23'd120;
				CFG_INTEG_GAIN: gi_q  <= 20'(cfg_data) * 20'd9;
				CFG_DERIV_GAIN: gd_q  <= 27'(cfg_data) * 27'd1600;
				CFG_TOP_SPEED:  top_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			whl_q       <= '0;
			mac_q       <= '0;
			pwm_valid_q <= 1'b0;
		end else begin
			if (pwm_valid_q && !pwm_stall) begin
				pwm_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (tick_valid) state_q <= ST_MAP;
				ST_MAP: begin
					whl_q   <= '0;
					state_q <= ST_RD;
				end
				ST_RD:  state_q <= ST_SP;
				ST_SP:  state_q <= ST_SPT;
				ST_SPT: state_q <= ST_SPD;
				ST_SPD: state_q <= ST_ERR;
				ST_ERR: begin
					mac_q   <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					mac_q <= mac_q + 1'b1;
					if (mac_q == 3'd5) state_q <= ST_WB;
				end
				ST_WB:  state_q <= ST_DIV;
				ST_DIV: begin
					if (drsp.done) begin
						if (whl_q == WHEEL_W'(WHEEL_COUNT - 1)) begin
							state_q <= ST_OUT;
						end else begin
							whl_q   <= whl_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_OUT: begin
					if (!pwm_valid_q || !pwm_stall) begin
						pwm_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tick_valid) tick_q <= tick;
		if (state_q == ST_MAP) begin
			xm_q <= xm_n;
			ym_q <= ym_n;
			w_q  <= w_n;
		end
		if (state_q == ST_RD) begin
			qv_q   <= qv_n;
			vneg_q <= vneg_n;
		end
		if (state_q == ST_SP) begin
			n2_q   <= n2_n;
			aneg_q <= aneg_n;
			mag_q  <= mag_n;
			dneg_q <= dneg_n;
			sat_q  <= sat_n;
		end
		if (state_q == ST_SPT) sp_q <= sp_n;
		if (state_q == ST_SPD) spd_q <= spd_n;
		if (state_q == ST_ERR) begin
			e_q     <= e_n;
			de_q    <= de_n;
			integ_q <= integ_n;
			acc_q   <= '0;
		end
		if (state_q == ST_MAC) acc_q <= acc_q + term;
		if (state_q == ST_DIV && drsp.done) begin
			case (whl_q)
				2'd0: begin res_q.fwd_a <= drsp.fwd; res_q.rev_a <= drsp.rev; end
				2'd1: begin res_q.fwd_b <= drsp.fwd; res_q.rev_b <= drsp.rev; end
				default: begin res_q.fwd_c <= drsp.fwd; res_q.rev_c <= drsp.rev; end
			endcase
		end
		if (state_q == ST_OUT && (!pwm_valid_q || !pwm_stall)) pwm_q <= res_q;
	end

endmodule

@@ hw/rtl/omni3_state_mem.sv @@
// per-wheel state memory with registered read
module omni3_state_mem
	import omni3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mem_req_t  req,
	output st_entry_t rdata
);

	st_entry_t              mem_q [WHEEL_COUNT];
	logic [WHEEL_COUNT-1:0] valid_q;
	st_entry_t              rdata_q;

	// valid bits, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr) begin
			valid_q[req.addr] <= 1'b1;
		end
	end

	// storage and registered read port
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= valid_q[req.addr] ? mem_q[req.addr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/omni3_pwm_div.sv @@
// drive divide by fifteen, four bits a cycle, then fold modulo the pwm range
module omni3_pwm_div
	import omni3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int NIB   = QW / 4;
	localparam int CNT_W = $clog2(NIB);
	localparam int NCH   = (QW + PWM_BITS - 1) / PWM_BITS;
	localparam int QXW   = NCH * PWM_BITS;
	localparam int SW    = PWM_BITS + 3;
	localparam logic [4:0] DIVISOR = 5'd15;

	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_RUN  = 3'b010,
		DV_FOLD = 3'b100
	} dv_state_t;

	dv_state_t           state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [QW-1:0]       dvd_q;
	logic [QW-1:0]       quo_q;
	logic [3:0]          rem_q;
	logic                neg_q;
	logic                done_q;
	logic [PWM_BITS-1:0] fwd_q;
	logic [PWM_BITS-1:0] rev_q;

	logic [3:0]          rem_nxt;
	logic [3:0]          qbits;
	logic [QXW-1:0]      quo_x;
	logic [SW-1:0]       fold1;
	logic [PWM_BITS:0]   fold2;
	logic [PWM_BITS-1:0] fold3;
	logic [PWM_BITS-1:0] modv;

	// four restoring steps on the narrow remainder
	always_comb begin
		logic [3:0] r;
		logic [4:0] t;
		r = rem_q;
		qbits = '0;
		for (int i = 3; i >= 0; i--) begin
			t = {r, dvd_q[QW-4+i]};
			if (t >= DIVISOR) begin
				r = 4'(t - DIVISOR);
				qbits[i] = 1'b1;
			end else begin
				r = t[3:0];
			end
		end
		rem_nxt = r;
	end

	// residue modulo 2^PWM_BITS-1 by summing digit chunks
	always_comb begin
		quo_x = QXW'(quo_q);
		fold1 = '0;
		for (int k = 0; k < NCH; k++) begin
			fold1 = fold1 + SW'(quo_x[k*PWM_BITS +: PWM_BITS]);
		end
		fold2 = (PWM_BITS+1)'(fold1[PWM_BITS-1:0]) + (PWM_BITS+1)'(fold1[SW-1:PWM_BITS]);
		fold3 = fold2[PWM_BITS-1:0] + PWM_BITS'(fold2[PWM_BITS]);
		modv  = (fold3 == PWM_MOD) ? '0 : fold3;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DV_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NIB - 1)) begin
						state_q <= DV_FOLD;
					end
				end
				DV_FOLD: begin
					done_q  <= 1'b1;
					state_q <= DV_IDLE;
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && req.start) begin
			dvd_q <= req.mag;
			quo_q <= '0;
			rem_q <= '0;
			neg_q <= req.neg;
		end else if (state_q == DV_RUN) begin
			dvd_q <= dvd_q << 4;
			quo_q <= {quo_q[QW-5:0], qbits};
			rem_q <= rem_nxt;
		end
		if (state_q == DV_FOLD) begin
			fwd_q <= neg_q ? '0 : modv;
			rev_q <= neg_q ? modv : '0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.fwd  = fwd_q;
	assign rsp.rev  = rev_q;

endmodule

@@ hw/rtl/omni3_checker.sv @@
// port-level checks of the omni drive, bound to the top level
module omni3_checker
	import omni3_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  tick_valid,
	input logic  tick_stall,
	input logic  pwm_valid,
	input logic  pwm_stall,
	input pwm_t  pwm
);

	// a stalled result holds
	a_pwm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_valid && pwm_stall |=> pwm_valid && $stable(pwm))
		else $error("result changed while stalled");

	// one tick at a time: stall rises right after a transaction
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> tick_stall)
		else $error("second tick taken while busy");

	// forward and reverse never drive together
	a_dir_excl: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_valid |-> (pwm.fwd_a == '0 || pwm.rev_a == '0)
		           && (pwm.fwd_b == '0 || pwm.rev_b == '0)
		           && (pwm.fwd_c == '0 || pwm.rev_c == '0))
		else $error("both directions driven");

	// residue stays below the modulus
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_valid |-> pwm.fwd_a != PWM_MOD && pwm.rev_a != PWM_MOD
		           && pwm.fwd_b != PWM_MOD && pwm.rev_b != PWM_MOD
		           && pwm.fwd_c != PWM_MOD && pwm.rev_c != PWM_MOD)
		else $error("pwm value out of range");

endmodule

bind omni_three_wheel_pid_drive omni3_checker u_chk (.*);
